/* src/rsg_pkg.sv */
// ----------------------------------------------------------------------------
// Request spacing gate package
// Shared constants, request kinds and the request and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package rsg_pkg;

    // Default number of channels and the reset value of the spacing register.
    localparam int unsigned CHANNELS_DEF      = 4;
    localparam logic [31:0] SPACING_RESET_VAL = 32'd250000;

    // Request kinds.
    localparam logic [1:0] KIND_ALLOW = 2'd0;
    localparam logic [1:0] KIND_FORCE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // One incoming request.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  channel;
        logic [63:0] now_us;
    } t_req;

    // One result.
    typedef struct packed {
        logic        granted;
        logic        channel_ok;
        logic [31:0] honored_total;
        logic [31:0] dropped_total;
    } t_rsp;

endpackage

`default_nettype wire

/* src/rsg_in_reg.sv */
// ----------------------------------------------------------------------------
// Request spacing gate input register
// Holds one accepted request until the decision stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rsg_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire rsg_pkg::t_req i_req,
    output logic               o_valid,
    output rsg_pkg::t_req      o_req,
    input  wire logic          i_take
);
    import rsg_pkg::*;

    logic r_valid;
    t_req r_req;

    // The register is busy only when it holds a request that cannot move on.
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload loads on each accepted request.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req <= i_req;
        end
    end

endmodule

`default_nettype wire

/* src/rsg_table.sv */
// ----------------------------------------------------------------------------
// Request spacing gate channel table
// Per-channel anchor and counters, the spacing register and the decision.
// ----------------------------------------------------------------------------
`default_nettype none

module rsg_table #(
    parameter int unsigned CHANNELS = rsg_pkg::CHANNELS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_fire,
    input  wire rsg_pkg::t_req i_req,
    output rsg_pkg::t_rsp      o_rsp
);
    import rsg_pkg::*;

    localparam int unsigned IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [8:0]  CH_LIMIT = 9'(CHANNELS);

    logic [63:0] r_anchor  [CHANNELS];
    logic [31:0] r_honored [CHANNELS];
    logic [31:0] r_dropped [CHANNELS];
    logic [31:0] r_spacing;

    logic             ch_ok;
    logic [IDX_W-1:0] idx;
    logic [63:0]      last;
    logic [31:0]      hon;
    logic [31:0]      drp;
    logic [63:0]      gap;
    logic             too_soon;
    logic [63:0]      n_anchor;
    logic [31:0]      n_honored;
    logic [31:0]      n_dropped;
    logic             granted;

    // Channel range check and read of the addressed entry.
    assign ch_ok = {1'b0, i_req.channel} < CH_LIMIT;
    assign idx   = i_req.channel[IDX_W-1:0];

    always_comb begin
        last = '0;
        hon  = '0;
        drp  = '0;
        if (ch_ok) begin
            last = r_anchor[idx];
            hon  = r_honored[idx];
            drp  = r_dropped[idx];
        end
    end

    // An allow is refused when an anchor exists and the time is not far enough past it.
    assign gap      = i_req.now_us - last;
    assign too_soon = (last != 64'd0) &&
                      ((i_req.now_us <= last) || (gap < {32'd0, r_spacing}));

    // Next entry values for the request kind.
    always_comb begin
        n_anchor  = last;
        n_honored = hon;
        n_dropped = drp;
        granted   = 1'b1;
        unique case (i_req.kind)
            KIND_ALLOW: begin
                if (too_soon) begin
                    n_dropped = drp + 32'd1;
                    granted   = 1'b0;
                end else begin
                    n_anchor  = i_req.now_us;
                    n_honored = hon + 32'd1;
                end
            end
            KIND_FORCE: begin
                if (last < i_req.now_us) begin
                    n_anchor = i_req.now_us;
                end
                n_honored = hon + 32'd1;
            end
            KIND_QUERY: begin
            end
            KIND_CLEAR: begin
            end
            default: begin
            end
        endcase
        if (!ch_ok) begin
            granted = 1'b1;
        end
    end

    // Result record; counts read zero for out-of-range channels and clear all.
    always_comb begin
        o_rsp.granted       = granted;
        o_rsp.channel_ok    = ch_ok;
        o_rsp.honored_total = '0;
        o_rsp.dropped_total = '0;
        if (ch_ok && (i_req.kind != KIND_CLEAR)) begin
            o_rsp.honored_total = n_honored;
            o_rsp.dropped_total = n_dropped;
        end
    end

    // Spacing register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RESET_VAL;
        end else if (i_cfg_we) begin
            r_spacing <= i_cfg_data;
        end
    end

    // Channel state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_anchor[i]  <= '0;
                r_honored[i] <= '0;
                r_dropped[i] <= '0;
            end
        end else if (i_fire) begin
            if (i_req.kind == KIND_CLEAR) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_anchor[i]  <= '0;
                    r_honored[i] <= '0;
                    r_dropped[i] <= '0;
                end
            end else if (ch_ok) begin
                r_anchor[idx]  <= n_anchor;
                r_honored[idx] <= n_honored;
                r_dropped[idx] <= n_dropped;
            end
        end
    end

endmodule

`default_nettype wire

/* src/rsg_out_reg.sv */
// ----------------------------------------------------------------------------
// Request spacing gate result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rsg_out_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire rsg_pkg::t_rsp i_rsp,
    input  wire logic          i_stall,
    output logic               o_free,
    output logic               o_valid,
    output rsg_pkg::t_rsp      o_rsp
);
    import rsg_pkg::*;

    logic r_valid;
    t_rsp r_rsp;

    // The register can take a new result when empty or being emptied.
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

`default_nettype wire

/* src/per_channel_request_spacing_gate_unit.sv */
// ----------------------------------------------------------------------------
// Per-channel request spacing gate
// Grants allow requests on in-range channels only at a minimum spacing in time,
// with honored and dropped counters per channel.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         i_in_valid / o_in_stall    i_kind, i_channel, i_now_us
//   result    out        o_out_valid / i_out_stall  o_granted, o_channel_ok,
//                                                   o_honored_total,
//                                                   o_dropped_total
//   config    in         i_cfg_we                   i_cfg_data
//
// One request is taken every cycle unless the result side stalls; its result is
// presented once the result register has loaded it from the input register.
// The decision and the table update sit between the input and result registers.
// Reset clears all channels and loads the spacing register with 250000.
// A stall on the result side holds both registers and then the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_request_spacing_gate_unit #(
    parameter int unsigned CHANNELS = rsg_pkg::CHANNELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_channel,
    input  wire logic [63:0] i_now_us,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_granted,
    output logic             o_channel_ok,
    output logic [31:0]      o_honored_total,
    output logic [31:0]      o_dropped_total
);
    import rsg_pkg::*;

    t_req in_req;
    t_req held_req;
    t_rsp dec_rsp;
    t_rsp out_rsp;
    logic held_valid;
    logic out_free;
    logic fire;

    // Pack the request fields.
    assign in_req.kind    = i_kind;
    assign in_req.channel = i_channel;
    assign in_req.now_us  = i_now_us;

    // A held request is decided when the result register can take it.
    assign fire = held_valid && out_free;

    // Input register.
    rsg_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (in_req),
        .o_valid (held_valid),
        .o_req   (held_req),
        .i_take  (out_free)
    );

    // Channel table and decision.
    rsg_table #(
        .CHANNELS (CHANNELS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_req      (held_req),
        .o_rsp      (dec_rsp)
    );

    // Result register.
    rsg_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (held_valid),
        .i_rsp   (dec_rsp),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_rsp   (out_rsp)
    );

    // Unpack the result fields.
    assign o_granted       = out_rsp.granted;
    assign o_channel_ok    = out_rsp.channel_ok;
    assign o_honored_total = out_rsp.honored_total;
    assign o_dropped_total = out_rsp.dropped_total;

endmodule

`default_nettype wire
